FILE: rtl/asf_pkg.sv
// ----------------------------------------------------------------------------
// asf_pkg
// Shared constants, types and helpers of the alternating sequential filter.
// ----------------------------------------------------------------------------
`default_nettype none

package asf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int PIXEL_BITS = 8;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WID_W      = 11;
  localparam int HGT_W      = 13;
  // Room for the largest height plus the rows of the drain tail
  localparam int ROW_W      = 14;
  localparam int WIN        = 5;
  localparam int LB_ROWS    = WIN - 1;
  localparam int DRAIN_W    = 14;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;
  localparam int STAGES     = 8;

  // Register index, taken from address bit 2
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [WID_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [HGT_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [WID_W-1:0] MIN_DIM_W    = 11'd5;
  localparam logic [HGT_W-1:0] MIN_DIM_H    = 13'd5;
  localparam logic [WID_W-1:0] MAX_WIDTH_W  = WID_W'(MAX_WIDTH);

  // Per stage: bit s set means stage s takes the max / uses a 5x5 window
  localparam logic [STAGES-1:0] STAGE_TAKES_MAX = 8'b1001_1001;
  localparam logic [STAGES-1:0] STAGE_WIDE      = 8'b1111_0000;

  typedef logic [PIXEL_BITS-1:0] pix_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic have;
    pix_t pix;
  } token_t;

  typedef struct packed {
    logic             adv;
    logic             restart;
    logic [WID_W-1:0] used_w;
    logic [HGT_W-1:0] used_h;
  } ctrl_t;

  function automatic pix_t asf_pick(input pix_t a, input pix_t b, input logic take_max);
    if (take_max) begin
      return (a > b) ? a : b;
    end
    return (a < b) ? a : b;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/asf_if.sv
// ----------------------------------------------------------------------------
// asf_if
// Stream channels of the filter: pixel words in, result words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface asf_in_if;
  import asf_pkg::*;
  logic valid;
  logic ready;
  logic opcode;
  pix_t pixel_in;
  modport source(output valid, output opcode, output pixel_in, input ready);
  modport sink(input valid, input opcode, input pixel_in, output ready);
endinterface

interface asf_out_if;
  import asf_pkg::*;
  logic valid;
  logic ready;
  pix_t pixel_out;
  logic last;
  modport source(output valid, output pixel_out, output last, input ready);
  modport sink(input valid, input pixel_out, input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/asf_feed.sv
// ----------------------------------------------------------------------------
// asf_feed
// Frame position tracking at the intake: turns accepted words into tokens.
// ----------------------------------------------------------------------------
`default_nettype none

module asf_feed (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire asf_pkg::ctrl_t ctrl,
  input  wire logic           take,
  input  wire logic           opcode,
  input  wire asf_pkg::pix_t  pix,
  output asf_pkg::token_t     tok
);
  import asf_pkg::*;

  logic [ROW_W-1:0]   irow;
  logic [COL_W-1:0]   icol;
  logic [DRAIN_W-1:0] dcnt;
  logic               intake;
  logic               row_end;
  logic [DRAIN_W-1:0] drain_end;
  logic               is_last;

  assign intake    = irow < ROW_W'(ctrl.used_h);
  assign row_end   = {1'b0, icol} == (ctrl.used_w - 11'd1);
  // 12*W + 12 drain words flush the cascade; this is the index of the last one
  assign drain_end = {ctrl.used_w, 3'b000} + {1'b0, ctrl.used_w, 2'b00} + 14'd11;
  assign is_last   = !intake && (dcnt == drain_end);

  // Advance frame position, drop drain words during intake
  always_ff @(posedge clk) begin
    if (rst || ctrl.restart) begin
      irow <= '0;
      icol <= '0;
      dcnt <= '0;
      tok  <= '0;
    end else if (ctrl.adv) begin
      tok.valid <= take && (!opcode || !intake);
      tok.last  <= take && is_last;
      tok.have  <= 1'b1;
      tok.pix   <= pix;
      if (take) begin
        if (intake) begin
          if (!opcode) begin
            if (row_end) begin
              icol <= '0;
              irow <= irow + ROW_W'(1);
            end else begin
              icol <= icol + 10'd1;
            end
          end
        end else if (is_last) begin
          irow <= '0;
          icol <= '0;
          dcnt <= '0;
        end else begin
          dcnt <= dcnt + 14'd1;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/asf_rank.sv
// ----------------------------------------------------------------------------
// asf_rank
// One rank stage: line memories, window columns and a clipped min/max tree.
// ----------------------------------------------------------------------------
`default_nettype none

module asf_rank (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire asf_pkg::ctrl_t  ctrl,
  input  wire logic            take_max,
  input  wire logic            wide,
  input  wire asf_pkg::token_t tok_in,
  output asf_pkg::token_t      tok_out
);
  import asf_pkg::*;

  logic [1:0]       rad;
  logic [ROW_W-1:0] irow;
  logic [COL_W-1:0] icol;
  logic [ROW_W-1:0] orow;
  logic [COL_W-1:0] ocol;

  logic             a_valid;
  logic             a_last;
  pix_t             a_pix;
  logic [ROW_W-1:0] a_row;
  logic [COL_W-1:0] a_col;
  pix_t             rd [LB_ROWS];

  pix_t             colreg [WIN-1][WIN];
  pix_t             newcol [WIN];
  logic             outlive;
  logic [ROW_W+1:0] rsum;
  logic [COL_W+1:0] csum;
  logic             row_ok [WIN];
  logic             col_ok [WIN];
  pix_t             neutral;
  pix_t             l0 [25];
  pix_t             l1 [13];
  pix_t             l2 [7];
  pix_t             l3 [4];
  pix_t             l4 [2];
  pix_t             best;

  assign rad = wide ? 2'd2 : 2'd1;

  // Line memories: memory k holds the row k+1 above the input row
  genvar k;
  generate
    for (k = 0; k < LB_ROWS; k++) begin : g_line
      pix_t mem [MAX_WIDTH];
      always_ff @(posedge clk) begin
        if (ctrl.adv && tok_in.valid) begin
          rd[k] <= mem[icol];
        end
        if (ctrl.adv && a_valid) begin
          mem[a_col] <= (k == 0) ? a_pix : rd[(k == 0) ? 0 : k - 1];
        end
      end
    end
  endgenerate

  // Input side: latch the word with its frame position
  always_ff @(posedge clk) begin
    if (rst || ctrl.restart) begin
      irow    <= '0;
      icol    <= '0;
      a_valid <= 1'b0;
    end else if (ctrl.adv) begin
      a_valid <= tok_in.valid;
      if (tok_in.valid) begin
        if (tok_in.last) begin
          irow <= '0;
          icol <= '0;
        end else if ({1'b0, icol} == (ctrl.used_w - 11'd1)) begin
          icol <= '0;
          irow <= irow + ROW_W'(1);
        end else begin
          icol <= icol + 10'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      a_last <= tok_in.last;
      a_pix  <= tok_in.pix;
      a_row  <= irow;
      a_col  <= icol;
    end
  end

  // Newest column: incoming pixel on top of the stored rows
  always_comb begin
    newcol[0] = a_pix;
    for (int i = 1; i < WIN; i++) begin
      newcol[i] = rd[i-1];
    end
  end

  // Shift window columns
  always_ff @(posedge clk) begin
    if (ctrl.adv && a_valid) begin
      colreg[0] <= newcol;
      for (int j = 1; j < WIN - 1; j++) begin
        colreg[j] <= colreg[j-1];
      end
    end
  end

  // Output position lags the input by rad rows and rad columns
  assign outlive = (a_row > ROW_W'(rad)) ||
                   ((a_row == ROW_W'(rad)) && (a_col >= COL_W'(rad)));
  assign rsum    = {2'b00, orow} + (ROW_W+2)'(rad);
  assign csum    = {2'b00, ocol} + (COL_W+2)'(rad);

  // Clip the window to the frame
  always_comb begin
    for (int i = 0; i < WIN; i++) begin
      row_ok[i] = (3'(i) <= {rad, 1'b0}) && (rsum >= (ROW_W+2)'(i)) &&
                  ((rsum - (ROW_W+2)'(i)) < (ROW_W+2)'(ctrl.used_h));
      col_ok[i] = (3'(i) <= {rad, 1'b0}) && (csum >= (COL_W+2)'(i)) &&
                  ((csum - (COL_W+2)'(i)) < (COL_W+2)'(ctrl.used_w));
    end
  end

  assign neutral = take_max ? '0 : '1;

  // Rank tree over the masked window
  always_comb begin
    for (int i = 0; i < WIN; i++) begin
      for (int j = 0; j < WIN; j++) begin
        if (row_ok[i] && col_ok[j]) begin
          l0[i*WIN+j] = (j == 0) ? newcol[i] : colreg[(j == 0) ? 0 : j - 1][i];
        end else begin
          l0[i*WIN+j] = neutral;
        end
      end
    end
    for (int m = 0; m < 12; m++) l1[m] = asf_pick(l0[2*m], l0[2*m+1], take_max);
    l1[12] = l0[24];
    for (int m = 0; m < 6; m++) l2[m] = asf_pick(l1[2*m], l1[2*m+1], take_max);
    l2[6] = l1[12];
    for (int m = 0; m < 3; m++) l3[m] = asf_pick(l2[2*m], l2[2*m+1], take_max);
    l3[3] = l2[6];
    for (int m = 0; m < 2; m++) l4[m] = asf_pick(l3[2*m], l3[2*m+1], take_max);
    best = asf_pick(l4[0], l4[1], take_max);
  end

  // Output side: advance output position, register the result word
  always_ff @(posedge clk) begin
    if (rst || ctrl.restart) begin
      orow    <= '0;
      ocol    <= '0;
      tok_out <= '0;
    end else if (ctrl.adv) begin
      tok_out.valid <= a_valid && outlive;
      tok_out.last  <= a_last;
      tok_out.have  <= orow < ROW_W'(ctrl.used_h);
      tok_out.pix   <= best;
      if (a_valid && outlive) begin
        if (a_last) begin
          orow <= '0;
          ocol <= '0;
        end else if ({1'b0, ocol} == (ctrl.used_w - 11'd1)) begin
          ocol <= '0;
          orow <= orow + ROW_W'(1);
        end else begin
          ocol <= ocol + 10'd1;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/alternating_sequential_filter_top.sv
// ----------------------------------------------------------------------------
// alternating_sequential_filter_top
// 3x3 then 5x5 closing/opening cascade on a raster grayscale stream.
// ----------------------------------------------------------------------------
// One word is taken per clock while the result side keeps up. The result for
// pixel k leaves on the word 12*W+12 words later (W = used width), delayed
// further by the pipeline registers: each of the eight rank stages has an
// input register, whose line-memory reads are registered, and an output
// register after its min/max tree. After the last pixel, send 12*W+12 drain
// words; the final one returns the result flagged last. Each stage keeps four
// line memories of 1024 pixels. Write width and height only while idle; a
// write restarts the frame.
`default_nettype none

module alternating_sequential_filter_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  asf_in_if.sink                              pixels,
  asf_out_if.source                           results,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [asf_pkg::ADDR_W-1:0]     paddr,
  input  wire logic [asf_pkg::DATA_W-1:0]     pwdata,
  output logic      [asf_pkg::DATA_W-1:0]     prdata,
  output logic                                pready
);
  import asf_pkg::*;

  logic [WID_W-1:0] width_reg;
  logic [HGT_W-1:0] height_reg;
  logic             wr_en;
  ctrl_t            ctrl;
  token_t           tok [STAGES+1];

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= WIDTH_RESET;
      height_reg <= HEIGHT_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_WIDTH:  width_reg  <= pwdata[WID_W-1:0];
        REG_HEIGHT: height_reg <= pwdata[HGT_W-1:0];
        default:    ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (paddr[2])
      REG_WIDTH:  prdata = DATA_W'(width_reg);
      REG_HEIGHT: prdata = DATA_W'(height_reg);
      default:    prdata = '0;
    endcase
  end

  // Saturate the frame size, stall the whole cascade on a held result
  always_comb begin
    ctrl.restart = wr_en;
    if (width_reg < MIN_DIM_W) begin
      ctrl.used_w = MIN_DIM_W;
    end else if (width_reg > MAX_WIDTH_W) begin
      ctrl.used_w = MAX_WIDTH_W;
    end else begin
      ctrl.used_w = width_reg;
    end
    ctrl.used_h = (height_reg < MIN_DIM_H) ? MIN_DIM_H : height_reg;
    ctrl.adv    = !results.valid || results.ready;
  end

  assign pixels.ready = ctrl.adv;

  asf_feed u_feed (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .take   (pixels.valid),
    .opcode (pixels.opcode),
    .pix    (pixels.pixel_in),
    .tok    (tok[0])
  );

  genvar s;
  generate
    for (s = 0; s < STAGES; s++) begin : g_stage
      asf_rank u_rank (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (ctrl),
        .take_max (STAGE_TAKES_MAX[s]),
        .wide     (STAGE_WIDE[s]),
        .tok_in   (tok[s]),
        .tok_out  (tok[s+1])
      );
    end
  endgenerate

  // Only words inside the frame leave as results
  assign results.valid     = tok[STAGES].valid && tok[STAGES].have;
  assign results.pixel_out = tok[STAGES].pix;
  assign results.last      = tok[STAGES].last;

endmodule

`default_nettype wire

FILE: tb/sv/asf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asf_checker
// Watches the pixel and result channels and the register port, predicts every
// filtered word from its own model of the eight-stage cascade and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module asf_checker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  asf_in_if                                  pixels,
  asf_out_if                                 results,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic                          pready,
  input  wire logic [asf_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [asf_pkg::DATA_W-1:0]    pwdata,
  output int                                 errors,
  output int                                 pending,
  output int                                 checked
);
  import asf_pkg::*;

  typedef struct {
    pix_t pix;
    logic last;
  } filtered_t;

  filtered_t want_q[$];

  // Model state: one five-row ring per stage, frame geometry, word count
  pix_t        ring [STAGES][5][MAX_WIDTH];
  int unsigned width_reg;
  int unsigned height_reg;
  longint      frame_tick;

  function automatic int unsigned stage_radius(int s);
    return STAGE_WIDE[s] ? 2 : 1;
  endfunction

  // Rank of the window around pos, clipped to the frame
  function automatic pix_t window_rank(int s, int unsigned pos, int unsigned w,
                                       int unsigned h);
    int unsigned rad, span, row, col, r0, r1, c0, c1;
    pix_t best, v;
    rad  = stage_radius(s);
    span = 2 * rad + 1;
    row  = pos / w;
    col  = pos % w;
    r0   = (row >= rad) ? row - rad : 0;
    r1   = (row + rad < h) ? row + rad : h - 1;
    c0   = (col >= rad) ? col - rad : 0;
    c1   = (col + rad < w) ? col + rad : w - 1;
    best = STAGE_TAKES_MAX[s] ? 8'h00 : 8'hff;
    for (int unsigned r = r0; r <= r1; r++) begin
      for (int unsigned c = c0; c <= c1; c++) begin
        v = ring[s][r % span][c];
        if (STAGE_TAKES_MAX[s] ? (v > best) : (v < best)) best = v;
      end
    end
    return best;
  endfunction

  // Advance the cascade by one word; returns 1 when a filtered pixel leaves
  function automatic bit cascade_step(logic drain, pix_t pin, output filtered_t res);
    int unsigned w, h, rad, span;
    longint      total, pos, delay;
    bit          have, live;
    pix_t        val;
    w = width_reg < 5 ? 5 : (width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg);
    h = height_reg < 5 ? 5 : height_reg;
    total = longint'(w) * h;
    pos   = frame_tick;
    have  = pos < total;
    live  = 1;
    val   = pin;
    res.pix  = '0;
    res.last = 1'b0;
    if (drain && pos < total) return 0;
    for (int s = 0; s < STAGES; s++) begin
      rad   = stage_radius(s);
      span  = 2 * rad + 1;
      delay = longint'(rad) * w + rad;
      if (have) ring[s][(int'(pos) / w) % span][int'(pos) % w] = val;
      pos -= delay;
      if (pos < 0) begin
        live = 0;
        break;
      end
      if (pos < total) begin
        val  = window_rank(s, int'(pos), w, h);
        have = 1;
      end else begin
        have = 0;
      end
    end
    if (live && have) begin
      res.pix  = val;
      res.last = (pos == total - 1);
      frame_tick = res.last ? 0 : frame_tick + 1;
      return 1;
    end
    frame_tick++;
    return 0;
  endfunction

  assign pending = want_q.size();

  always @(posedge clk) begin
    filtered_t got, exp_word;
    if (rst) begin
      want_q.delete();
      width_reg  <= 640;
      height_reg <= 480;
      frame_tick <= 0;
      errors     <= 0;
      checked    <= 0;
      foreach (ring[s, r, c]) ring[s][r][c] = '0;
    end else begin
      // Register writes restart the frame
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_WIDTH) width_reg = pwdata[WID_W-1:0];
        else                       height_reg = pwdata[HGT_W-1:0];
        frame_tick = 0;
      end
      // Compare the word leaving against the oldest expectation
      if (results.valid && results.ready) begin
        if (want_q.size() == 0) begin
          $display("%0t: unexpected word pixel_out=%0d last=%0b", $time,
                   results.pixel_out, results.last);
          errors <= errors + 1;
        end else begin
          exp_word = want_q.pop_front();
          checked <= checked + 1;
          if (results.pixel_out !== exp_word.pix || results.last !== exp_word.last) begin
            $display("%0t: mismatch expected pixel_out=%0d last=%0b, got pixel_out=%0d last=%0b",
                     $time, exp_word.pix, exp_word.last, results.pixel_out, results.last);
            errors <= errors + 1;
          end
        end
      end
      // Predict from the word entering
      if (pixels.valid && pixels.ready) begin
        if (cascade_step(pixels.opcode, pixels.pixel_in, got)) want_q.push_back(got);
      end
    end
  end

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives frames of random and extreme pixels with drain tails and noise words
// through the filter under varied stalls; the checker judges every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import asf_pkg::*;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                errors, pending, checked;
  int                send_idle = 0;
  int                take_idle = 0;
  int                hold_cycles = 0;
  bit                hold_req = 0;
  int                words_sent = 0;
  int                frames_run = 0;
  int unsigned       used_w, used_h;

  asf_in_if  pixels ();
  asf_out_if results ();

  alternating_sequential_filter_top dut (
    .clk(clk), .rst(rst), .pixels(pixels), .results(results),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  asf_checker checker_i (
    .clk(clk), .rst(rst), .pixels(pixels), .results(results),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .errors(errors), .pending(pending), .checked(checked)
  );

  always #4 clk = ~clk;

  initial begin
    pixels.valid    = 1'b0;
    pixels.opcode   = 1'b0;
    pixels.pixel_in = '0;
    results.ready   = 1'b0;
  end

  // Result side: random back-pressure, plus a long hold-off on request
  initial begin
    int left;
    left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        left = hold_cycles;
        hold_req = 0;
      end
      if (left > 0) begin
        results.ready <= 1'b0;
        left--;
      end else begin
        results.ready <= ($urandom_range(99) >= take_idle);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("tb failed");
    $finish;
  end

  // Register write: setup then access phase
  task automatic reg_write(logic idx, logic [DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_WIDTH) begin
      used_w = val[WID_W-1:0] < 5 ? 5 : (val[WID_W-1:0] > MAX_WIDTH ? MAX_WIDTH
                                                                    : val[WID_W-1:0]);
    end else begin
      used_h = val[HGT_W-1:0] < 5 ? 5 : val[HGT_W-1:0];
    end
  endtask

  // Offer one word, idling at random first; return after acceptance
  task automatic send_word(logic op, pix_t pix);
    while ($urandom_range(99) < send_idle) begin
      pixels.valid <= 1'b0;
      @(negedge clk);
    end
    pixels.valid    <= 1'b1;
    pixels.opcode   <= op;
    pixels.pixel_in <= pix;
    do @(posedge clk); while (!pixels.ready);
    words_sent++;
    @(negedge clk);
  endtask

  // Let the block go quiet before touching registers
  task automatic settle();
    pixels.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    @(negedge clk);
  endtask

  // One frame; style 0 random, 1 extremes, 2 ramp. Noise adds ignored drains
  // during intake and extra pixels in the tail.
  task automatic run_frame(int style, bit noise);
    int unsigned n, tail;
    pix_t p;
    n = used_w * used_h;
    tail = 12 * used_w + 12;
    for (int unsigned k = 0; k < n; k++) begin
      if (noise && $urandom_range(19) == 0) send_word(1'b1, pix_t'($urandom));
      case (style)
        1:       p = $urandom_range(1) ? 8'hff : 8'h00;
        2:       p = pix_t'(k * 37);
        default: p = pix_t'($urandom);
      endcase
      send_word(1'b0, p);
    end
    for (int unsigned k = 0; k < tail; k++) begin
      send_word(noise ? logic'($urandom_range(1)) : 1'b1, pix_t'($urandom));
    end
    frames_run++;
    settle();
  endtask

  task automatic random_frames(int quota);
    int start;
    start = words_sent;
    while (words_sent - start < quota) begin
      reg_write(REG_WIDTH, $urandom_range(5, 7));
      reg_write(REG_HEIGHT, $urandom_range(5, 6));
      run_frame($urandom_range(3) == 0 ? 1 : 0, $urandom_range(1));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: drain while idle, undersized geometry, extreme pixels
    send_idle = 28;
    take_idle = 79;
    reg_write(REG_WIDTH, 32'd0);
    reg_write(REG_HEIGHT, 32'd0);
    send_word(1'b1, 8'hff);
    for (int k = 0; k < 25; k++) send_word(1'b0, (k % 2) ? 8'hff : 8'h00);
    for (int k = 0; k < 72; k++) send_word(1'b1, 8'h00);
    settle();
    // Masked register bits: width reads back as 5
    reg_write(REG_WIDTH, 32'hffff_f805);
    reg_write(REG_HEIGHT, 32'd6);
    run_frame(2, 1'b0);

    random_frames(90);
    send_idle = 79;
    take_idle = 28;
    random_frames(90);

    // No idling: long result hold-off while the input keeps coming
    send_idle = 0;
    take_idle = 0;
    reg_write(REG_WIDTH, 32'd6);
    reg_write(REG_HEIGHT, 32'd5);
    hold_cycles = 2000;
    hold_req = 1;
    run_frame(0, 1'b1);
    random_frames(90);

    settle();
    $display("Ran %0d frames, %0d words offered, %0d filtered pixels checked.",
             frames_run + 1, words_sent, checked);
    if (errors == 0 && pending == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
